>>> rtl/cbm_pkg.sv
package cbm_pkg;

    // Input item kinds (tuser on the slave side)
    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_TICK  = 1'b1
    } t_kind;

    // Register regions, address bits 15..12
    typedef enum logic [3:0] {
        REGION_PRG16  = 4'h8,
        REGION_SOUND1 = 4'h9,
        REGION_SOUND2 = 4'hA,
        REGION_MIRROR = 4'hB,
        REGION_PRG8   = 4'hC,
        REGION_CHR_LO = 4'hD,
        REGION_CHR_HI = 4'hE,
        REGION_IRQ    = 4'hF
    } t_region;

    // Sub-register select, address bits 1..0 after the optional swap
    typedef enum logic [1:0] {
        SEL_0 = 2'd0,
        SEL_1 = 2'd1,
        SEL_2 = 2'd2,
        SEL_3 = 2'd3
    } t_sel;

    // IRQ control bits
    localparam int CTRL_ACK_EN = 0;
    localparam int CTRL_EN     = 1;
    localparam int CTRL_CYCLE  = 2;

    localparam logic [7:0] PRG8_RESET    = 8'hFE;
    localparam logic [7:0] COUNT_MAX     = 8'hFF;
    localparam logic [9:0] PRESCALE_STEP = 10'd3;
    localparam int         NUM_CHR       = 8;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_item;

    typedef struct packed {
        logic [1:0]               mirroring;
        logic [NUM_CHR-1:0][7:0]  chr_bank;
        logic [7:0]               prg_bank_8k;
        logic [7:0]               prg_bank_16k;
        logic                     irq_asserted;
    } t_map_view;

endpackage

>>> rtl/cartridge_bank_mapper_with_irq_top.sv
// Cartridge bank mapper with an 8-bit IRQ counter.
//
// Slave stream: one item per transfer. tuser = kind (0 CPU write, 1 CPU-cycle
// tick); tdata = address in [15:0], write data in [23:16]. Writes below 0x8000
// and to the sound registers change nothing but still return a result.
// Master stream: one result per input item, showing the mapper state after
// that item: IRQ pending, both PRG banks, eight CHR banks and mirroring.
// Config: i_cfg_we/i_cfg_wdata set the A0/A1 swap; write only while idle.
//
// Path from the input transfer to o_m_axis_tvalid: the input register, then the
// state update and the result register. Throughput: one item per clock while
// the receiver keeps tready high; the only loop is the state update in cbm_core.
// Stall: when the receiver holds tready low, the result register holds and the
// input register still takes one more item; o_s_axis_tready then drops until the
// result is taken.
// Reset (synchronous, active low): both stages empty, PRG banks 0 and 0xFE,
// CHR bank i = i, IRQ logic, mirroring and swap cleared.
module cartridge_bank_mapper_with_irq_top #(
    parameter int PRESCALE_RELOAD = 341
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // address[15:0], write_data[23:16]
    input  logic        i_s_axis_tuser,   // kind
    // master stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // irq_asserted[0], prg_bank_16k[8:1], prg_bank_8k[16:9],
    // chr_bank_0..7[80:17] (8 bits each, slot 0 lowest), mirroring[82:81], zero[87:83]
    output logic [87:0] o_m_axis_tdata,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata       // address_swap
);
    import cbm_pkg::*;

    logic       r_in_valid;
    t_item      r_in_item;
    logic       r_out_valid;
    t_map_view  r_out_view;
    t_map_view  core_next;
    logic       advance;
    logic       s_xfer;

    // item moves from the input register into the result register
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign s_xfer          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_in_item.kind       <= t_kind'(i_s_axis_tuser);
            r_in_item.address    <= i_s_axis_tdata[15:0];
            r_in_item.write_data <= i_s_axis_tdata[23:16];
        end
    end

    cbm_core #(
        .PRESCALE_RELOAD(PRESCALE_RELOAD)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_fire     (advance),
        .i_item     (r_in_item),
        .o_next     (core_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_view <= core_next;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out_view};

endmodule

>>> rtl/cbm_core.sv
module cbm_core #(
    parameter int PRESCALE_RELOAD = 341
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_fire,
    input  cbm_pkg::t_item    i_item,
    output cbm_pkg::t_map_view o_next
);
    import cbm_pkg::*;

    localparam logic [9:0] RELOAD_10 = 10'(PRESCALE_RELOAD);

    logic                     r_swap;
    logic [2:0]               r_irq_control, n_irq_control;
    logic [7:0]               r_irq_count, n_irq_count;
    logic [7:0]               r_irq_reload, n_irq_reload;
    logic [9:0]               r_prescaler, n_prescaler;
    logic                     r_irq_pending, n_irq_pending;
    logic [7:0]               r_prg16, n_prg16;
    logic [7:0]               r_prg8, n_prg8;
    logic [NUM_CHR-1:0][7:0]  r_chr, n_chr;
    logic [1:0]               r_mirror, n_mirror;

    t_sel    sel;
    t_region region;
    logic    clock_cnt;

    always_comb begin
        sel    = r_swap ? t_sel'({i_item.address[0], i_item.address[1]})
                        : t_sel'(i_item.address[1:0]);
        region = t_region'(i_item.address[15:12]);

        n_irq_control = r_irq_control;
        n_irq_count   = r_irq_count;
        n_irq_reload  = r_irq_reload;
        n_prescaler   = r_prescaler;
        n_irq_pending = r_irq_pending;
        n_prg16       = r_prg16;
        n_prg8        = r_prg8;
        n_chr         = r_chr;
        n_mirror      = r_mirror;
        clock_cnt     = 1'b0;

        if (i_item.kind == KIND_TICK) begin
            if (r_irq_control[CTRL_EN]) begin
                if (r_irq_control[CTRL_CYCLE]) begin
                    clock_cnt = 1'b1;
                end else if (r_prescaler < PRESCALE_STEP) begin
                    // 10-bit wrap matches the masked reload
                    n_prescaler = r_prescaler + RELOAD_10 - PRESCALE_STEP;
                    clock_cnt   = 1'b1;
                end else begin
                    n_prescaler = r_prescaler - PRESCALE_STEP;
                end
            end
            if (clock_cnt) begin
                if (r_irq_count == COUNT_MAX) begin
                    n_irq_count   = r_irq_reload;
                    n_irq_pending = 1'b1;
                end else begin
                    n_irq_count = r_irq_count + 8'd1;
                end
            end
        end else if (i_item.address[15]) begin
            unique case (region)
                REGION_PRG16: n_prg16 = i_item.write_data;
                REGION_PRG8:  n_prg8  = i_item.write_data;
                REGION_MIRROR: begin
                    if (sel == SEL_3) begin
                        n_mirror = i_item.write_data[3:2];
                    end
                end
                REGION_CHR_LO: n_chr[{1'b0, sel}] = i_item.write_data;
                REGION_CHR_HI: n_chr[{1'b1, sel}] = i_item.write_data;
                REGION_IRQ: begin
                    unique case (sel)
                        SEL_0: n_irq_reload = i_item.write_data;
                        SEL_1: begin
                            n_irq_control = i_item.write_data[2:0];
                            if (i_item.write_data[CTRL_EN]) begin
                                n_irq_count = r_irq_reload;
                                n_prescaler = RELOAD_10;
                            end
                            n_irq_pending = 1'b0;
                        end
                        SEL_2: begin
                            // ack: enable takes the enable-after-ack bit
                            n_irq_control[CTRL_EN] = r_irq_control[CTRL_ACK_EN];
                            n_irq_pending          = 1'b0;
                        end
                        SEL_3: ;  // sound register
                        default: ;
                    endcase
                end
                default: ;  // sound regions
            endcase
        end

        o_next.irq_asserted = n_irq_pending;
        o_next.prg_bank_16k = n_prg16;
        o_next.prg_bank_8k  = n_prg8;
        o_next.chr_bank     = n_chr;
        o_next.mirroring    = n_mirror;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap <= 1'b0;
        end else if (i_cfg_we) begin
            r_swap <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_control <= '0;
            r_irq_count   <= '0;
            r_irq_reload  <= '0;
            r_prescaler   <= '0;
            r_irq_pending <= 1'b0;
            r_prg16       <= '0;
            r_prg8        <= PRG8_RESET;
            for (int i = 0; i < NUM_CHR; i++) begin
                r_chr[i] <= 8'(i);
            end
            r_mirror      <= '0;
        end else if (i_fire) begin
            r_irq_control <= n_irq_control;
            r_irq_count   <= n_irq_count;
            r_irq_reload  <= n_irq_reload;
            r_prescaler   <= n_prescaler;
            r_irq_pending <= n_irq_pending;
            r_prg16       <= n_prg16;
            r_prg8        <= n_prg8;
            r_chr         <= n_chr;
            r_mirror      <= n_mirror;
        end
    end

endmodule

>>> rtl/cbm_checker.sv
module cbm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [87:0] o_m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // reset empties the result stage
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // with the result stage empty the input side never backpressures
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

    // an accepted item with the output free shows up after the input and result registers
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (!o_m_axis_tvalid || i_m_axis_tready)
            |=> ##1 o_m_axis_tvalid)
        else $error("accepted item lost");

    // pad bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[87:83] == 5'b0)
        else $error("pad bits nonzero");

endmodule

bind cartridge_bank_mapper_with_irq_top cbm_checker u_cbm_checker (.*);
